FILE: design/svb_pkg.sv
// Shared types, codes and the arithmetic helper of the skinned vertex bounds block.
package svb_pkg;

  // Default sizes
  localparam int unsigned PaletteSizeDef   = 256;
  localparam int unsigned SetInfluencesDef = 4;
  localparam int unsigned ElemsPerBone     = 12;
  localparam int unsigned Influences       = 8;

  // Command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SKIN  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic signed [31:0] Int32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Int32Min = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [63:0]        bone_indices;
    logic [63:0]        weights_first;
    logic [63:0]        weights_second;
    logic [7:0]         bone_slot;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] skinned_x;
    logic signed [31:0] skinned_y;
    logic signed [31:0] skinned_z;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_SKIN,
    JOB_CLEAR
  } job_e;

  typedef struct packed {
    job_e     kind;
    in_item_t item;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [51:0] hi;
    logic signed [51:0] lo;
    hi = 52'(Int32Max);
    lo = 52'(Int32Min);
    if (v > hi) begin
      return Int32Max;
    end else if (v < lo) begin
      return Int32Min;
    end
    return v[31:0];
  endfunction

endpackage

FILE: design/skinned_vertex_bounds_core.sv
// Top level of the skinned vertex bounds block.
// Linear blend skinning with eight influences and a running bounding box. A load item
// writes one element of a bone matrix into the palette, a clear item resets the box; both
// are handled in the back end and give no result. A skin item goes through the back end
// in steps: it starts, reads the eight bone matrices through the single read port of
// the palette banks (one matrix a cycle), lets the transform and blend pipeline drain,
// and then rounds, updates the box and places the result. That last step waits while
// the previous result is still unread. Items are queued two deep in front of the back
// end, and one finished result waits in an output register.
module skinned_vertex_bounds_core #(
  parameter int unsigned PALETTE_SIZE   = svb_pkg::PaletteSizeDef,
  parameter int unsigned SET_INFLUENCES = svb_pkg::SetInfluencesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  svb_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output svb_pkg::out_item_t result_o
);
  import svb_pkg::*;

  logic job_valid, job_ready;
  job_t job;

  svb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_ready_i(job_ready)
  );

  svb_back #(
    .PALETTE_SIZE  (PALETTE_SIZE),
    .SET_INFLUENCES(SET_INFLUENCES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job),
    .job_ready_o(job_ready),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

endmodule

FILE: design/svb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                                            clk_i,
  input  logic                                            we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]    waddr_i,
  input  logic [Width-1:0]                                wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]    raddr_i,
  output logic [Width-1:0]                                rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/svb_front.sv
// Front end: accepts items, classifies the command and queues jobs for the back end.
module svb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  svb_pkg::in_item_t item_i,
  output logic            job_valid_o,
  output svb_pkg::job_t   job_o,
  input  logic            job_ready_i
);
  import svb_pkg::*;

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       accept, keep, deq;
  job_t       job_new;

  // Classify the command; unused codes are dropped
  always_comb begin
    job_new.item = item_i;
    job_new.kind = JOB_LOAD;
    keep         = 1'b1;
    unique case (item_i.cmd)
      CMD_LOAD:  job_new.kind = JOB_LOAD;
      CMD_SKIN:  job_new.kind = JOB_SKIN;
      CMD_CLEAR: job_new.kind = JOB_CLEAR;
      default:   keep         = 1'b0;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign accept      = push && !full;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = entry_q[rd_ptr_q];
  assign deq         = job_valid_o && job_ready_i;

  // Store queue entries
  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      entry_q[wr_ptr_q] <= job_new;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept && keep) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(accept && keep) - 2'(deq);
    end
  end

endmodule

FILE: design/svb_back.sv
// Back end: palette memory, bone transform pipeline, blending and bounding box.
module svb_back #(
  parameter int unsigned PALETTE_SIZE   = svb_pkg::PaletteSizeDef,
  parameter int unsigned SET_INFLUENCES = svb_pkg::SetInfluencesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  svb_pkg::job_t     job_i,
  output logic              job_ready_o,
  output logic              empty,
  input  logic              pop,
  output svb_pkg::out_item_t result_o
);
  import svb_pkg::*;

  localparam int unsigned AddrW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [8:0]  PalLim = 9'(PALETTE_SIZE);
  localparam logic [2:0]  SetLim = 3'(SET_INFLUENCES);

  state_e state_q, state_d;

  // Control decode
  logic do_load, do_clear, do_start, do_issue, do_fin, can_fin;
  logic [ElemsPerBone-1:0] we;

  // Latched vertex
  logic signed [31:0] pos_q [3];
  logic [63:0] idx_q, wf_q, ws_q;
  logic [2:0]  cnt_q;

  // Issue signals
  logic [7:0]       slot;
  logic [15:0]      wgt;
  logic             inf_ok;
  logic [AddrW-1:0] raddr;
  logic [31:0]      rdata [ElemsPerBone];

  // Pipeline tags
  logic        v1_q, v2_q, v3_q, v4_q;
  logic        l1_q, l2_q, l3_q, l4_q;
  logic [15:0] w1_q, w2_q, w3_q;
  logic        acc_done_q;

  logic signed [63:0] prod_q [9];
  logic signed [31:0] tr_q [3];
  logic signed [31:0] crd_q [3];
  logic signed [47:0] wtd_q [3];
  logic signed [51:0] acc_q [3];

  logic signed [31:0] box_min_q [3], box_max_q [3];
  logic signed [31:0] vtx [3], nmin [3], nmax [3];

  out_item_t out_q;
  logic      out_vld_q;

  // Palette banks, one per matrix element
  for (genvar e = 0; e < ElemsPerBone; e++) begin : g_bank
    svb_ram #(
      .Width(32),
      .Depth(PALETTE_SIZE)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[e]),
      .waddr_i(job_i.item.bone_slot[AddrW-1:0]),
      .wdata_i(job_i.item.elem_value),
      .raddr_i(raddr),
      .rdata_o(rdata[e])
    );
  end

  // Select the influence being issued
  always_comb begin
    slot   = idx_q[8*cnt_q +: 8];
    wgt    = cnt_q[2] ? ws_q[16*cnt_q[1:0] +: 16] : wf_q[16*cnt_q[1:0] +: 16];
    inf_ok = ({1'b0, cnt_q[1:0]} < SetLim) && ({1'b0, slot} < PalLim);
    raddr  = slot[AddrW-1:0];
  end

  assign can_fin = !out_vld_q || pop;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (job_valid_i && job_i.kind == JOB_SKIN) state_d = ST_ISSUE;
      ST_ISSUE: if (cnt_q == 3'd7) state_d = ST_DRAIN;
      ST_DRAIN: if (acc_done_q) state_d = ST_DONE;
      ST_DONE:  if (can_fin) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    job_ready_o = 1'b0;
    do_load     = 1'b0;
    do_clear    = 1'b0;
    do_start    = 1'b0;
    do_issue    = 1'b0;
    do_fin      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        job_ready_o = job_valid_i;
        do_load     = job_valid_i && (job_i.kind == JOB_LOAD);
        do_clear    = job_valid_i && (job_i.kind == JOB_CLEAR);
        do_start    = job_valid_i && (job_i.kind == JOB_SKIN);
      end
      ST_ISSUE: do_issue = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  do_fin = can_fin;
      default:  ;
    endcase
  end

  // Bank write enables
  always_comb begin
    we = '0;
    if (do_load && ({1'b0, job_i.item.bone_slot} < PalLim)
        && (job_i.item.elem_index < 4'(ElemsPerBone))) begin
      we[job_i.item.elem_index] = 1'b1;
    end
  end

  // Hold the vertex being skinned
  always_ff @(posedge clk_i) begin
    if (do_start) begin
      pos_q[0] <= job_i.item.pos_x;
      pos_q[1] <= job_i.item.pos_y;
      pos_q[2] <= job_i.item.pos_z;
      idx_q    <= job_i.item.bone_indices;
      wf_q     <= job_i.item.weights_first;
      ws_q     <= job_i.item.weights_second;
    end
  end

  // Transform datapath; stages run every cycle
  always_ff @(posedge clk_i) begin
    w1_q <= wgt;
    w2_q <= w1_q;
    w3_q <= w2_q;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r*3+c] <= pos_q[r] * $signed(rdata[r*3+c]);
      end
      tr_q[c]  <= $signed(rdata[9+c]);
      crd_q[c] <= sat32(52'((67'(prod_q[c]) + 67'(prod_q[3+c]) + 67'(prod_q[6+c])
                  + (67'(tr_q[c]) <<< 16) + 67'sd32768) >>> 16));
      wtd_q[c] <= 48'($signed({1'b0, w3_q}) * crd_q[c]);
    end
  end

  // Accumulate weighted coordinates
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (do_start) begin
        acc_q[c] <= '0;
      end else if (v4_q) begin
        acc_q[c] <= acc_q[c] + 52'(wtd_q[c]);
      end
    end
  end

  // Advance pipeline tags and the issue counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      l1_q       <= 1'b0;
      l2_q       <= 1'b0;
      l3_q       <= 1'b0;
      l4_q       <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= do_start ? 3'd0 : (do_issue ? cnt_q + 3'd1 : cnt_q);
      v1_q       <= do_issue && inf_ok;
      l1_q       <= do_issue && (cnt_q == 3'd7);
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      v4_q       <= v3_q;
      l2_q       <= l1_q;
      l3_q       <= l2_q;
      l4_q       <= l3_q;
      acc_done_q <= l4_q;
    end
  end

  // Round the blend and fold it into the box
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vtx[c]  = sat32((acc_q[c] + 52'sd16384) >>> 15);
      nmin[c] = (vtx[c] < box_min_q[c]) ? vtx[c] : box_min_q[c];
      nmax[c] = (vtx[c] > box_max_q[c]) ? vtx[c] : box_max_q[c];
    end
  end

  // Box registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        box_min_q[c] <= Int32Max;
        box_max_q[c] <= Int32Min;
      end
    end else if (do_clear) begin
      for (int c = 0; c < 3; c++) begin
        box_min_q[c] <= Int32Max;
        box_max_q[c] <= Int32Min;
      end
    end else if (do_fin) begin
      box_min_q <= nmin;
      box_max_q <= nmax;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (do_fin) begin
      out_q.skinned_x <= vtx[0];
      out_q.skinned_y <= vtx[1];
      out_q.skinned_z <= vtx[2];
      out_q.box_min_x <= nmin[0];
      out_q.box_min_y <= nmin[1];
      out_q.box_min_z <= nmin[2];
      out_q.box_max_x <= nmax[0];
      out_q.box_max_y <= nmax[1];
      out_q.box_max_z <= nmax[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (do_fin) begin
      out_vld_q <= 1'b1;
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  assign empty    = !out_vld_q;
  assign result_o = out_q;

  // A job is taken only when one is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_ready_o |-> job_valid_i)
    else $error("job taken from an empty queue");

  // The last influence reaches the accumulator only while draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done_q |-> (state_q == ST_DRAIN))
    else $error("accumulation finished outside drain");

  // No palette write while a vertex is being read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (we == '0))
    else $error("palette written during skinning");

  // A waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_fin |-> (!out_vld_q || pop))
    else $error("result overwritten");

endmodule
